### sv/protocol_event_trigger_core_assert.svh
// Assertion macros for the protocol event trigger core.
// Included by the top level; expects clk and rst_n in scope.
`ifndef PROTOCOL_EVENT_TRIGGER_CORE_ASSERT_SVH
`define PROTOCOL_EVENT_TRIGGER_CORE_ASSERT_SVH

`ifndef SYNTH
`define PETC_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define PETC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define PETC_ASSERT_IMPLY(lbl, ante, cons)
`define PETC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### sv/petc_pkg.sv
// Shared types, codes and constants of the protocol event trigger core.
// No dependencies; imported by every module of the block.
package petc_pkg;

    localparam int FILTER_SLOTS_DEF = 8;
    localparam int SLOT_W           = 6;
    localparam int MTYPE_W          = 5;
    localparam int DOCS_W           = 3;
    localparam int EV_W             = 4;
    localparam int MODE_W           = 4;
    localparam int CNT_W            = 32;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 48;
    localparam int IN_TDATA_W       = 16;
    localparam int OUT_TDATA_W      = 40;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_REPEAT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MASK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_TABLE = 3'd4;

    // Trigger modes
    localparam logic [MODE_W-1:0] MODE_OFF       = 4'd0;
    localparam logic [MODE_W-1:0] MODE_PREAMBLE  = 4'd1;
    localparam logic [MODE_W-1:0] MODE_CRC       = 4'd10;
    localparam logic [MODE_W-1:0] MODE_ANY_ERROR = 4'd11;

    // Event codes
    localparam logic [EV_W-1:0] EV_DATA          = 4'd3;
    localparam logic [EV_W-1:0] EV_COMPLETE      = 4'd4;
    localparam logic [EV_W-1:0] EV_HARD_RESET    = 4'd5;
    localparam logic [EV_W-1:0] EV_RUNT          = 4'd6;
    localparam logic [EV_W-1:0] EV_CRC           = 4'd9;
    localparam logic [EV_W-1:0] EV_TMO_PRE_START = 4'd10;

    localparam logic CMD_REARM = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE      = 2'd0,
        ST_ARMED     = 2'd1,
        ST_TRIGGERED = 2'd2
    } status_t;

    typedef struct packed {
        logic [MODE_W-1:0] trigger_mode;
        logic [CNT_W-1:0]  event_threshold;
        logic              auto_repeat;
    } cfg_t;

    typedef struct packed {
        logic             counted;
        logic             sync_pulse;
        logic [CNT_W-1:0] event_total;
        status_t          trigger_status;
    } result_t;

endpackage

### sv/petc_cfg_regs.sv
// Configuration register file of the protocol event trigger core.
// Depends on petc_pkg.
module petc_cfg_regs #(
    parameter int FILTER_SLOTS = petc_pkg::FILTER_SLOTS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_we,
    input  logic [petc_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [petc_pkg::CFG_DATA_W-1:0]          cfg_data,
    output petc_pkg::cfg_t                           cfg,
    output logic [FILTER_SLOTS-1:0]                  filt_mask,
    output logic [FILTER_SLOTS*petc_pkg::SLOT_W-1:0] filt_table,
    output logic                                     cfg_rearm
);
    import petc_pkg::*;

    cfg_t                           cfg_reg;
    logic [FILTER_SLOTS-1:0]        mask_reg;
    logic [FILTER_SLOTS*SLOT_W-1:0] table_reg;
    logic                           rearm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_mode    <= MODE_OFF;
            cfg_reg.event_threshold <= CNT_W'(1);
            cfg_reg.auto_repeat     <= 1'b0;
            mask_reg                <= '0;
            table_reg               <= '0;
            rearm_reg               <= 1'b0;
        end
        else
        begin
            // writes to mode, threshold or repeat restart the count in the cycle after the write,
            // once the new mode is visible to the status logic
            rearm_reg <= cfg_we && (cfg_index inside {REG_TRIGGER_MODE, REG_THRESHOLD,
                                                     REG_AUTO_REPEAT});
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TRIGGER_MODE: cfg_reg.trigger_mode    <= cfg_data[MODE_W-1:0];
                    REG_THRESHOLD:    cfg_reg.event_threshold <= cfg_data[CNT_W-1:0];
                    REG_AUTO_REPEAT:  cfg_reg.auto_repeat     <= cfg_data[0];
                    REG_FILTER_MASK:  mask_reg  <= cfg_data[FILTER_SLOTS-1:0];
                    REG_FILTER_TABLE: table_reg <= cfg_data[FILTER_SLOTS*SLOT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign cfg_rearm  = rearm_reg;
    assign cfg        = cfg_reg;
    assign filt_mask  = mask_reg;
    assign filt_table = table_reg;

endmodule

### sv/petc_match.sv
// Event matcher: trigger-mode decode and message-type filter compare.
// Depends on petc_pkg.
module petc_match #(
    parameter int FILTER_SLOTS = petc_pkg::FILTER_SLOTS_DEF
) (
    input  logic [petc_pkg::MODE_W-1:0]              trigger_mode,
    input  logic [FILTER_SLOTS-1:0]                  filt_mask,
    input  logic [FILTER_SLOTS*petc_pkg::SLOT_W-1:0] filt_table,
    input  logic [petc_pkg::EV_W-1:0]                event_code,
    input  logic                                     header_present,
    input  logic [petc_pkg::MTYPE_W-1:0]             message_type,
    input  logic [petc_pkg::DOCS_W-1:0]              data_object_count,
    output logic                                     hit
);
    import petc_pkg::*;

    logic              mode_ok;
    logic              hdr_known;
    logic              filt_on;
    logic              filt_hit;
    logic [SLOT_W-1:0] cand;

    always_comb
    begin
        mode_ok = 1'b0;
        if (trigger_mode inside {[MODE_PREAMBLE:MODE_CRC]})
            mode_ok = (event_code == (trigger_mode - MODE_W'(1)));
        else if (trigger_mode == MODE_ANY_ERROR)
            mode_ok = (event_code inside {[EV_RUNT:EV_CRC]});
    end

    always_comb
    begin
        if (event_code == EV_DATA)
            hdr_known = 1'b1;
        else if (event_code inside {EV_COMPLETE, EV_HARD_RESET, [EV_RUNT:EV_TMO_PRE_START]})
            hdr_known = header_present;
        else
            hdr_known = 1'b0;
    end

    assign cand    = {(data_object_count != '0), message_type};
    assign filt_on = |filt_mask;

    always_comb
    begin
        filt_hit = 1'b0;
        for (int i = 0; i < FILTER_SLOTS; i++)
            if (filt_mask[i] && (filt_table[i*SLOT_W +: SLOT_W] == cand))
                filt_hit = 1'b1;
    end

    assign hit = mode_ok && !(filt_on && hdr_known && !filt_hit);

endmodule

### sv/petc_counter.sv
// Event counter, repeat phase and trigger status; builds one result per item.
// Depends on petc_pkg.
module petc_counter (
    input  logic              clk,
    input  logic              rst_n,
    input  petc_pkg::cfg_t    cfg,
    input  logic              cfg_rearm,
    input  logic              step,
    input  logic              rearm_cmd,
    input  logic              hit,
    output petc_pkg::result_t res
);
    import petc_pkg::*;

    status_t          status_reg,  status_next;
    logic [CNT_W-1:0] counter_reg, counter_next;
    logic [CNT_W-1:0] phase_reg,   phase_next;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] ph_inc;
    logic             thr_nz;
    logic             pulse;
    status_t          rearm_status;

    assign cnt_inc      = counter_reg + CNT_W'(1);
    assign ph_inc       = phase_reg + CNT_W'(1);
    assign thr_nz       = (cfg.event_threshold != '0);
    assign rearm_status = (cfg.trigger_mode == MODE_OFF) ? ST_IDLE : ST_ARMED;

    always_comb
    begin
        status_next  = status_reg;
        counter_next = counter_reg;
        phase_next   = phase_reg;
        pulse        = 1'b0;
        if (rearm_cmd)
        begin
            status_next  = rearm_status;
            counter_next = '0;
            phase_next   = '0;
        end
        else if (hit)
        begin
            counter_next = cnt_inc;
            if (cfg.auto_repeat)
            begin
                if (thr_nz && (ph_inc >= cfg.event_threshold))
                begin
                    phase_next = '0;
                    pulse      = 1'b1;
                end
                else
                    phase_next = ph_inc;
            end
            else if (thr_nz && (cnt_inc == cfg.event_threshold))
            begin
                status_next = ST_TRIGGERED;
                pulse       = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg  <= ST_IDLE;
            counter_reg <= '0;
            phase_reg   <= '0;
        end
        else if (cfg_rearm)
        begin
            status_reg  <= rearm_status;
            counter_reg <= '0;
            phase_reg   <= '0;
        end
        else if (step)
        begin
            status_reg  <= status_next;
            counter_reg <= counter_next;
            phase_reg   <= phase_next;
        end
    end

    assign res.trigger_status = status_next;
    assign res.event_total    = counter_next;
    assign res.sync_pulse     = pulse;
    assign res.counted        = !rearm_cmd && hit;

endmodule

### sv/protocol_event_trigger_core.sv
// Top level of the protocol event trigger core.
// Depends on petc_pkg, petc_cfg_regs, petc_match, petc_counter and the assert header.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tuser: command; tdata: event fields
//  m_      | out | m_tvalid/m_tready  | tdata: status, total, pulse, counted
//  cfg_    | in  | cfg_we             | cfg_index, cfg_data
//
// One transfer in per cycle while the output is not stalled, one result out per item.
// Input register feeds the matcher and counter; the result register holds the
// result until taken. A stalled output stops the input register only when full.
// rst_n clears counter, status, config and all valid flags.
module protocol_event_trigger_core #(
    parameter int FILTER_SLOTS = petc_pkg::FILTER_SLOTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [3:0] event_code, [4] header_present, [9:5] message_type,
    // [12:10] data_object_count, [15:13] zero
    input  logic [petc_pkg::IN_TDATA_W-1:0]   s_tdata,
    // [0] command
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [1:0] trigger_status, [33:2] event_total, [34] sync_pulse,
    // [35] counted, [39:36] zero
    output logic [petc_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                              cfg_we,
    input  logic [petc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [petc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import petc_pkg::*;

    `include "protocol_event_trigger_core_assert.svh"

    cfg_t                           cfg;
    logic [FILTER_SLOTS-1:0]        filt_mask;
    logic [FILTER_SLOTS*SLOT_W-1:0] filt_table;
    logic                           cfg_rearm;

    logic               in_valid_reg;
    logic               in_cmd_reg;
    logic [EV_W-1:0]    in_ev_reg;
    logic               in_hdr_reg;
    logic [MTYPE_W-1:0] in_mtype_reg;
    logic [DOCS_W-1:0]  in_docs_reg;

    logic               out_valid_reg;
    result_t            out_res_reg;

    logic               advance;
    logic               hit;
    result_t            res;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    petc_cfg_regs #(
        .FILTER_SLOTS(FILTER_SLOTS)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg        (cfg),
        .filt_mask  (filt_mask),
        .filt_table (filt_table),
        .cfg_rearm  (cfg_rearm)
    );

    petc_match #(
        .FILTER_SLOTS(FILTER_SLOTS)
    ) u_match (
        .trigger_mode      (cfg.trigger_mode),
        .filt_mask         (filt_mask),
        .filt_table        (filt_table),
        .event_code        (in_ev_reg),
        .header_present    (in_hdr_reg),
        .message_type      (in_mtype_reg),
        .data_object_count (in_docs_reg),
        .hit               (hit)
    );

    petc_counter u_counter (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cfg_rearm (cfg_rearm),
        .step      (advance),
        .rearm_cmd (in_cmd_reg == CMD_REARM),
        .hit       (hit),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg   <= s_tuser;
            in_ev_reg    <= s_tdata[3:0];
            in_hdr_reg   <= s_tdata[4];
            in_mtype_reg <= s_tdata[9:5];
            in_docs_reg  <= s_tdata[12:10];
        end
        if (advance)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - $bits(result_t))'(0), out_res_reg};

    `PETC_ASSERT_IMPLY(a_pulse_needs_count, out_valid_reg && out_res_reg.sync_pulse,
                       out_res_reg.counted)
    `PETC_ASSERT_IMPLY(a_once_pulse_triggers,
                       out_valid_reg && out_res_reg.sync_pulse && !cfg.auto_repeat,
                       out_res_reg.trigger_status == ST_TRIGGERED)
    `PETC_ASSERT_NEXT(a_rearm_clears_total, advance && (in_cmd_reg == CMD_REARM),
                      (out_res_reg.event_total == '0) && !out_res_reg.counted)

endmodule

### test/protocol_event_trigger_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for protocol_event_trigger_core: directed and random event streams
// with random stalls on both sides, checked against an in-bench trigger predictor.
// Depends on petc_pkg and the core RTL only.
module protocol_event_trigger_core_test;
    import petc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 53;

    // codes with no name in the package
    localparam logic           CMD_EVENT     = 1'b0;
    localparam logic [EV_W-1:0] EV_PREAMBLE   = 4'd0;
    localparam logic [EV_W-1:0] EV_SOP        = 4'd1;
    localparam logic [EV_W-1:0] EV_HEADER     = 4'd2;
    localparam logic [EV_W-1:0] EV_TIMEOUT    = 4'd7;
    localparam logic [EV_W-1:0] EV_KCODE      = 4'd8;
    localparam logic [EV_W-1:0] EV_LAST_CODE  = 4'd10;
    localparam logic [MODE_W-1:0] MODE_DATA     = 4'd4;
    localparam logic [MODE_W-1:0] MODE_COMPLETE = 4'd5;
    localparam logic [MODE_W-1:0] MODE_TOP      = 4'd15;

    typedef struct packed {
        logic              cmd;
        logic [EV_W-1:0]   ev;
        logic              hdr;
        logic [MTYPE_W-1:0] mtype;
        logic [DOCS_W-1:0] docs;
    } msg_event_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor copy of configuration and state
    logic [MODE_W-1:0]  trig_mode = MODE_OFF;
    logic [CNT_W-1:0]   trig_threshold = 1;
    logic               trig_repeat = 1'b0;
    logic [7:0]         trig_mask = '0;
    logic [CFG_DATA_W-1:0] trig_table = '0;
    status_t            trig_status = ST_IDLE;
    logic [CNT_W-1:0]   trig_count = '0;
    logic [CNT_W-1:0]   trig_phase = '0;

    msg_event_t event_queue[$];
    result_t    trigger_reports[$];
    int events_queued = 0;
    int events_taken = 0;
    int errors = 0;
    int cycles = 0;
    logic took_event = 1'b0;
    logic no_idle = 1'b0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    always #4 clk = ~clk;

    protocol_event_trigger_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    function automatic void rearm_trigger();
        trig_count = '0;
        trig_phase = '0;
        trig_status = (trig_mode == MODE_OFF) ? ST_IDLE : ST_ARMED;
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_TRIGGER_MODE:
            begin
                trig_mode = val[MODE_W-1:0];
                rearm_trigger();
            end
            REG_THRESHOLD:
            begin
                trig_threshold = val[CNT_W-1:0];
                rearm_trigger();
            end
            REG_AUTO_REPEAT:
            begin
                trig_repeat = val[0];
                rearm_trigger();
            end
            REG_FILTER_MASK:  trig_mask = val[7:0];
            REG_FILTER_TABLE: trig_table = val;
            default: ;
        endcase
    endfunction

    function automatic result_t advance_trigger(msg_event_t it);
        result_t r;
        logic mode_hit;
        logic hdr_known;
        logic slot_hit;
        logic [SLOT_W-1:0] cand;
        r = '0;
        if (it.cmd == CMD_REARM) begin
            rearm_trigger();
        end else begin
            if (trig_mode >= MODE_PREAMBLE && trig_mode <= MODE_CRC)
                mode_hit = (it.ev == trig_mode - MODE_PREAMBLE);
            else if (trig_mode == MODE_ANY_ERROR)
                mode_hit = (it.ev >= EV_RUNT && it.ev <= EV_CRC);
            else
                mode_hit = 1'b0;
            // completion and error events carry a header only when decoded
            hdr_known = (it.ev == EV_DATA) ||
                        (it.ev >= EV_COMPLETE && it.ev <= EV_TMO_PRE_START && it.hdr);
            cand = {it.docs != '0, it.mtype};
            slot_hit = 1'b0;
            for (int i = 0; i < FILTER_SLOTS_DEF; i++)
                if (trig_mask[i] && trig_table[SLOT_W*i +: SLOT_W] == cand)
                    slot_hit = 1'b1;
            if (mode_hit && !((|trig_mask) && hdr_known && !slot_hit)) begin
                r.counted = 1'b1;
                trig_count = trig_count + 1;
                if (trig_repeat) begin
                    trig_phase = trig_phase + 1;
                    if (trig_threshold != '0 && trig_phase >= trig_threshold) begin
                        trig_phase = '0;
                        r.sync_pulse = 1'b1;
                    end
                end else if (trig_threshold != '0 && trig_count == trig_threshold) begin
                    trig_status = ST_TRIGGERED;
                    r.sync_pulse = 1'b1;
                end
            end
        end
        r.trigger_status = trig_status;
        r.event_total = trig_count;
        return r;
    endfunction

    task automatic check_field(string what, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin : sample
        msg_event_t it;
        result_t want;
        result_t got;
        cycles++;
        if (cfg_we)
            apply_register(cfg_index, cfg_data);
        if (rst_n && s_tvalid && s_tready) begin
            it.cmd = s_tuser;
            {it.docs, it.mtype, it.hdr, it.ev} = s_tdata[12:0];
            trigger_reports.push_back(advance_trigger(it));
            events_taken++;
            took_event <= 1'b1;
        end else begin
            took_event <= 1'b0;
        end
        if (rst_n && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[35:0]);
            if (trigger_reports.size() == 0) begin
                errors++;
                $display("%0t ns: result with none expected, expected nothing, actual %h",
                         $time, m_tdata);
            end else begin
                want = trigger_reports.pop_front();
                check_field("trigger_status", CNT_W'(want.trigger_status),
                            CNT_W'(got.trigger_status));
                check_field("event_total", want.event_total, got.event_total);
                check_field("sync_pulse", CNT_W'(want.sync_pulse), CNT_W'(got.sync_pulse));
                check_field("counted", CNT_W'(want.counted), CNT_W'(got.counted));
                check_field("padding", '0, CNT_W'(m_tdata[39:36]));
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // sender: next transfer once the current one is taken
    always @(negedge clk)
    begin : sender
        msg_event_t it;
        if (rst_n && (!s_tvalid || took_event)) begin
            if (event_queue.size() > 0 && (no_idle || $urandom_range(0, 99) >= 8)) begin
                it = event_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= it.cmd;
                s_tdata <= {3'b000, it.docs, it.mtype, it.hdr, it.ev};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin : receiver
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= rst_n && (no_idle || $urandom_range(0, 99) >= 8);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic queue_event(logic cmd, logic [EV_W-1:0] ev, logic hdr,
                               logic [MTYPE_W-1:0] mtype, logic [DOCS_W-1:0] docs);
        msg_event_t it;
        it.cmd = cmd;
        it.ev = ev;
        it.hdr = hdr;
        it.mtype = mtype;
        it.docs = docs;
        event_queue.push_back(it);
        events_queued++;
    endtask

    // mostly events of the armed kind; half take their header from a filter table slot
    task automatic queue_random_event();
        int roll;
        logic [EV_W-1:0] ev;
        logic [SLOT_W-1:0] slot;
        logic [MTYPE_W-1:0] mtype;
        logic [DOCS_W-1:0] docs;
        roll = $urandom_range(0, 99);
        ev = EV_W'($urandom_range(0, EV_LAST_CODE));
        if (roll < 60) begin
            if (trig_mode >= MODE_PREAMBLE && trig_mode <= MODE_CRC)
                ev = trig_mode - MODE_PREAMBLE;
            else if (trig_mode == MODE_ANY_ERROR)
                ev = EV_W'($urandom_range(EV_RUNT, EV_CRC));
        end
        mtype = MTYPE_W'($urandom_range(0, 31));
        docs = DOCS_W'($urandom_range(0, 7));
        if ($urandom_range(0, 1)) begin
            slot = trig_table[SLOT_W*$urandom_range(0, FILTER_SLOTS_DEF-1) +: SLOT_W];
            mtype = slot[MTYPE_W-1:0];
            docs = slot[MTYPE_W] ? DOCS_W'($urandom_range(1, 7)) : '0;
        end
        queue_event(roll >= 94, ev, 1'($urandom_range(0, 1)), mtype, docs);
    endtask

    task automatic wait_drained();
        while (events_taken != events_queued || trigger_reports.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [63:0] wide;
        int pick;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // mode off, every register written with its reset value
        write_reg(REG_TRIGGER_MODE, CFG_DATA_W'(MODE_OFF));
        write_reg(REG_THRESHOLD, 1);
        write_reg(REG_AUTO_REPEAT, 0);
        write_reg(REG_FILTER_MASK, 0);
        write_reg(REG_FILTER_TABLE, 0);
        queue_event(CMD_EVENT, EV_PREAMBLE, 0, 0, 0);
        queue_event(CMD_REARM, EV_TMO_PRE_START, 1, 31, 7);
        wait_drained();

        // fire once at two, then latch triggered
        write_reg(REG_TRIGGER_MODE, CFG_DATA_W'(MODE_PREAMBLE));
        write_reg(REG_THRESHOLD, 2);
        queue_event(CMD_EVENT, EV_PREAMBLE, 0, 0, 0);
        queue_event(CMD_EVENT, EV_SOP, 1, 5, 2);
        queue_event(CMD_EVENT, EV_PREAMBLE, 1, 31, 7);
        queue_event(CMD_EVENT, EV_PREAMBLE, 0, 3, 1);
        queue_event(CMD_REARM, EV_PREAMBLE, 0, 0, 0);
        wait_drained();

        // any error, repeat every two, one slot for type 4 with data objects
        write_reg(REG_TRIGGER_MODE, CFG_DATA_W'(MODE_ANY_ERROR));
        write_reg(REG_AUTO_REPEAT, 1);
        write_reg(REG_FILTER_MASK, CFG_DATA_W'(8'h01));
        write_reg(REG_FILTER_TABLE, 48'h24);
        queue_event(CMD_EVENT, EV_TMO_PRE_START, 1, 4, 1);
        queue_event(CMD_EVENT, EV_RUNT, 0, 31, 7);
        queue_event(CMD_EVENT, EV_TIMEOUT, 1, 4, 1);
        queue_event(CMD_EVENT, EV_KCODE, 1, 4, 0);
        queue_event(CMD_EVENT, EV_CRC, 1, 4, 7);
        queue_event(CMD_EVENT, EV_RUNT, 1, 31, 7);
        queue_event(CMD_EVENT, EV_CRC, 0, 0, 0);
        wait_drained();

        // zero threshold, all slots on, data header always known
        write_reg(REG_TRIGGER_MODE, CFG_DATA_W'(MODE_DATA));
        write_reg(REG_THRESHOLD, 0);
        write_reg(REG_FILTER_MASK, CFG_DATA_W'(8'hFF));
        write_reg(REG_FILTER_TABLE, {CFG_DATA_W{1'b1}});
        queue_event(CMD_EVENT, EV_DATA, 0, 31, 7);
        queue_event(CMD_EVENT, EV_DATA, 0, 0, 0);
        wait_drained();

        write_reg(REG_TRIGGER_MODE, CFG_DATA_W'(MODE_COMPLETE));
        write_reg(REG_THRESHOLD, CFG_DATA_W'(32'hFFFF_FFFF));
        write_reg(REG_AUTO_REPEAT, 0);
        queue_event(CMD_EVENT, EV_COMPLETE, 0, 0, 0);
        queue_event(CMD_EVENT, EV_COMPLETE, 1, 31, 1);
        wait_drained();

        // unused mode code counts nothing but reads as armed
        write_reg(REG_TRIGGER_MODE, CFG_DATA_W'(MODE_TOP));
        queue_event(CMD_EVENT, EV_HEADER, 1, 7, 3);
        queue_event(CMD_EVENT, EV_HARD_RESET, 1, 31, 7);
        queue_event(CMD_REARM, EV_HEADER, 0, 0, 0);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            pick = $urandom_range(0, 3);
            write_reg(REG_TRIGGER_MODE,
                      CFG_DATA_W'((pick == 0) ? $urandom_range(0, MODE_TOP)
                                              : $urandom_range(MODE_PREAMBLE, MODE_ANY_ERROR)));
            case ($urandom_range(0, 5))
                0: write_reg(REG_THRESHOLD, 0);
                1: write_reg(REG_THRESHOLD, 1);
                2: write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(2, 4)));
                3: write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(2, 12)));
                4: write_reg(REG_THRESHOLD, CFG_DATA_W'(32'hFFFF_FFFF));
                default: write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom));
            endcase
            write_reg(REG_AUTO_REPEAT, CFG_DATA_W'($urandom_range(0, 1)));
            case ($urandom_range(0, 3))
                0: write_reg(REG_FILTER_MASK, 0);
                1: write_reg(REG_FILTER_MASK, CFG_DATA_W'(8'hFF));
                default: write_reg(REG_FILTER_MASK, CFG_DATA_W'($urandom_range(0, 255)));
            endcase
            wide = {$urandom, $urandom};
            write_reg(REG_FILTER_TABLE, wide[CFG_DATA_W-1:0]);

            no_idle = (p == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
                queue_random_event();
            // long receiver hold-off while the sender keeps offering
            if (p == 2)
                hold_req++;
            wait_drained();
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (errors == 0 && trigger_reports.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/petc_pkg.sv
sv/petc_cfg_regs.sv
sv/petc_match.sv
sv/petc_counter.sv
sv/protocol_event_trigger_core.sv
test/protocol_event_trigger_core_test.sv
